### design/deadline_timer_queue_assert.svh
// assertion macros for the deadline timer queue
`ifndef DEADLINE_TIMER_QUEUE_ASSERT_SVH
`define DEADLINE_TIMER_QUEUE_ASSERT_SVH
// assert that a condition implies another on the same edge
`define DTQ_ASSERT_IMP(label, a, b) \
  label: assert property (@(posedge clk) disable iff (!rst_n) (a) |-> (b)) \
    else $error("assertion failed");
// assert that a condition implies another on the next edge
`define DTQ_ASSERT_NEXT(label, a, b) \
  label: assert property (@(posedge clk) disable iff (!rst_n) (a) |=> (b)) \
    else $error("assertion failed");
`endif

### design/dtq_pkg.sv
// ----------------------------------------------------------------------------
// dtq_pkg
// shared types and constants of the deadline timer queue
// ----------------------------------------------------------------------------
package dtq_pkg;

  localparam int TimersDefault   = 16;
  localparam int MinDelayDefault = 100;
  localparam int ResultLimit     = 16;
  localparam int TimeW           = 48;
  localparam int PeriodW         = 32;

  typedef enum logic [1:0] {
    OP_ADD    = 2'd0,
    OP_CANCEL = 2'd1,
    OP_TICK   = 2'd2,
    OP_NONE   = 2'd3
  } op_t;

  typedef enum logic [2:0] {
    ST_ADDED     = 3'd0,
    ST_FULL      = 3'd1,
    ST_CANCELLED = 3'd2,
    ST_UNKNOWN   = 3'd3,
    ST_EXPIRED   = 3'd4,
    ST_NONE_DUE  = 3'd5
  } status_t;

  // one command between front and back
  typedef struct packed {
    op_t               op;
    logic [TimeW-1:0]  deadline;
    logic [PeriodW-1:0] period;
    logic [3:0]        target;
    logic [TimeW-1:0]  now;
  } cmd_t;

  // one result item
  typedef struct packed {
    status_t           status;
    logic [3:0]        slot;
    logic              earliest_changed;
    logic              rearm;
    logic [TimeW-1:0]  next_delay;
    logic              restarted;
    logic              last;
  } res_t;

endpackage

### design/dtq_front.sv
// ----------------------------------------------------------------------------
// dtq_front
// input queue: accepts operations, drops unknown codes, holds two commands
// ----------------------------------------------------------------------------
module dtq_front (
  input  logic          clk,
  input  logic          rst_n,
  input  logic          push,
  output logic          full,
  input  dtq_pkg::cmd_t cmd_in,
  output logic          cmd_valid,
  output dtq_pkg::cmd_t cmd_out,
  input  logic          cmd_take
);
  import dtq_pkg::*;

  cmd_t       mem_r [2];
  logic       wp_r, wp_nxt, rp_r, rp_nxt;
  logic [1:0] cnt_r, cnt_nxt;
  logic       wr, rd;

  assign full      = (cnt_r == 2'd2);
  // unknown operations are dropped here, never queued
  assign wr        = push && !full && (cmd_in.op != OP_NONE);
  assign cmd_valid = (cnt_r != 2'd0);
  assign rd        = cmd_valid && cmd_take;
  assign cmd_out   = mem_r[rp_r];

  always_comb begin
    wp_nxt  = wp_r ^ wr;
    rp_nxt  = rp_r ^ rd;
    cnt_nxt = cnt_r + {1'b0, wr} - {1'b0, rd};
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      wp_r  <= 1'b0;
      rp_r  <= 1'b0;
      cnt_r <= 2'd0;
    end else begin
      wp_r  <= wp_nxt;
      rp_r  <= rp_nxt;
      cnt_r <= cnt_nxt;
    end
  end

  always_ff @(posedge clk) begin
    if (wr) begin
      mem_r[wp_r] <= cmd_in;
    end
  end

endmodule

### design/dtq_back.sv
// ----------------------------------------------------------------------------
// dtq_back
// timer store and sequencer: scans slots one per cycle to place adds, pick,
// re-arm and find the earliest deadline
// ----------------------------------------------------------------------------
module dtq_back #(
  parameter int TIMERS       = dtq_pkg::TimersDefault,
  parameter int MIN_DELAY_US = dtq_pkg::MinDelayDefault
) (
  input  logic          clk,
  input  logic          rst_n,
  input  logic          cmd_valid,
  input  dtq_pkg::cmd_t cmd,
  output logic          cmd_take,
  output logic          res_valid,
  output dtq_pkg::res_t res,
  input  logic          res_take,
  output logic          busy
);
  import dtq_pkg::*;

  localparam int SW = (TIMERS > 1) ? $clog2(TIMERS) : 1;
  localparam int CW = $clog2(TIMERS + 1);
  localparam int KW = $clog2(ResultLimit + 1);
  localparam logic [TimeW-1:0] MinD = TimeW'(MIN_DELAY_US);
  localparam logic [TimeW-1:0] MaxT = {TimeW{1'b1}};

  typedef enum logic [7:0] {
    S_IDLE  = 8'b00000001,
    S_SCAN  = 8'b00000010,
    S_ADDW  = 8'b00000100,
    S_PICK  = 8'b00001000,
    S_EMIT  = 8'b00010000,
    S_REARM = 8'b00100000,
    S_MIN   = 8'b01000000,
    S_OUT   = 8'b10000000
  } state_t;

  state_t state_r, state_nxt;

  logic [TIMERS-1:0] live_r;
  logic [TIMERS-1:0] taken_r;
  logic [TimeW-1:0]  dl_mem [TIMERS];
  logic [PeriodW-1:0] per_mem [TIMERS];

  cmd_t              c_r;
  logic [CW-1:0]     idx_r;
  logic [SW-1:0]     ix;
  logic [SW-1:0]     free_r, best_r;
  logic              free_ok_r, earliest_r, best_ok_r, any_r;
  logic [TimeW-1:0]  best_dl_r, first_r;
  logic [KW-1:0]     count_r;
  logic [TimeW-1:0]  rd_dl;
  logic [PeriodW-1:0] rd_per;
  logic [TimeW:0]    sum;
  logic [TimeW-1:0]  diff;
  logic [TimeW-1:0]  delay;
  logic              rd_live;
  logic              more;
  logic              cancel_hit;
  logic              rv_set;
  res_t              res_r;
  logic              rv_r;

  assign ix       = idx_r[SW-1:0];
  assign rd_dl    = dl_mem[ix];
  assign rd_per   = per_mem[ix];
  assign rd_live  = live_r[ix];
  assign cmd_take = (state_r == S_IDLE) && !rv_r;
  assign res_valid = rv_r;
  assign res      = res_r;
  assign busy     = (state_r != S_IDLE);
  assign more     = (idx_r != CW'(TIMERS - 1));

  // slot numbers at or beyond TIMERS are never live
  assign cancel_hit = ({{(32-4){1'b0}}, cmd.target} < 32'(TIMERS)) &&
                      live_r[SW'(cmd.target)];

  // delay from now to the earliest deadline, floored
  assign diff  = first_r - c_r.now;
  assign delay = (first_r <= c_r.now || diff < MinD) ? MinD : diff;
  assign sum   = {1'b0, c_r.now} + {{(TimeW-PeriodW+1){1'b0}}, rd_per};

  always_comb begin
    unique case (state_r)
      S_IDLE:  state_nxt = S_IDLE;
      S_SCAN:  state_nxt = S_SCAN;
      S_ADDW:  state_nxt = S_ADDW;
      S_PICK:  state_nxt = S_PICK;
      S_EMIT:  state_nxt = S_EMIT;
      S_REARM: state_nxt = S_REARM;
      S_MIN:   state_nxt = S_MIN;
      S_OUT:   state_nxt = S_OUT;
      default: state_nxt = S_IDLE;
    endcase
  end

  // a transaction becomes visible when a result is complete, or when a held
  // expired result is proved not final by the next pick
  always_comb begin
    rv_set = 1'b0;
    unique case (state_r)
      S_IDLE:  rv_set = cmd_valid && !rv_r && (cmd.op == OP_CANCEL);
      S_ADDW:  rv_set = !free_ok_r;
      S_EMIT:  rv_set = (!rv_r || res_take) && (count_r != '0);
      S_OUT:   rv_set = (c_r.op == OP_ADD || count_r == '0) ? !rv_r : 1'b1;
      default: rv_set = 1'b0;
    endcase
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      rv_r <= 1'b0;
    end else if (rv_set) begin
      rv_r <= 1'b1;
    end else if (res_take) begin
      rv_r <= 1'b0;
    end
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      state_r <= S_IDLE;
      live_r  <= '0;
    end else begin
      unique case (state_nxt)
        S_IDLE: begin
          if (cmd_valid && !rv_r) begin
            c_r <= cmd;
            idx_r <= '0;
            free_ok_r <= 1'b0;
            earliest_r <= 1'b1;
            taken_r <= '0;
            count_r <= '0;
            any_r <= 1'b0;
            best_ok_r <= 1'b0;
            if (cmd.op == OP_CANCEL) begin
              res_r <= '{status: cancel_hit ? ST_CANCELLED : ST_UNKNOWN,
                         slot: cmd.target, earliest_changed: 1'b0,
                         rearm: 1'b0, next_delay: MinD, restarted: 1'b0, last: 1'b1};
              if (cancel_hit) begin
                live_r[SW'(cmd.target)] <= 1'b0;
              end
            end else if (cmd.op == OP_ADD) begin
              state_r <= S_SCAN;
            end else begin
              state_r <= S_PICK;
            end
          end
        end
        S_SCAN: begin
          if (rd_live) begin
            if (rd_dl <= c_r.deadline) earliest_r <= 1'b0;
          end else if (!free_ok_r) begin
            free_ok_r <= 1'b1;
            free_r <= ix;
          end
          idx_r <= idx_r + 1'b1;
          if (!more) state_r <= S_ADDW;
        end
        S_ADDW: begin
          first_r <= c_r.deadline;
          if (!free_ok_r) begin
            res_r <= '{status: ST_FULL, slot: 4'd0, earliest_changed: 1'b0,
                       rearm: 1'b0, next_delay: MinD, restarted: 1'b0, last: 1'b1};
            state_r <= S_IDLE;
          end else begin
            live_r[free_r] <= 1'b1;
            dl_mem[free_r] <= c_r.deadline;
            per_mem[free_r] <= c_r.period;
            state_r <= S_OUT;
          end
        end
        S_PICK: begin
          // one slot a cycle: earliest due, untaken; ties keep the lower slot
          if (rd_live && !taken_r[ix] && rd_dl <= c_r.now &&
              (!best_ok_r || rd_dl < best_dl_r)) begin
            best_ok_r <= 1'b1;
            best_r <= ix;
            best_dl_r <= rd_dl;
          end
          if (!more) begin
            idx_r <= '0;
            if (best_ok_r || (rd_live && !taken_r[ix] && rd_dl <= c_r.now)) begin
              state_r <= S_EMIT;
            end else begin
              state_r <= S_MIN;
            end
          end else begin
            idx_r <= idx_r + 1'b1;
          end
        end
        S_EMIT: begin
          if (!rv_r || res_take) begin
            taken_r[best_r] <= 1'b1;
            count_r <= count_r + 1'b1;
            best_ok_r <= 1'b0;
            idx_r <= CW'(best_r);
            state_r <= S_REARM;
          end
        end
        S_REARM: begin
          // the released transaction must be gone before the result is reused
          if (!rv_r || res_take) begin
            if (rd_per != '0) begin
              dl_mem[ix] <= sum[TimeW] ? MaxT : sum[TimeW-1:0];
            end else begin
              live_r[ix] <= 1'b0;
            end
            res_r <= '{status: ST_EXPIRED, slot: 4'(ix), earliest_changed: 1'b0,
                       rearm: 1'b0, next_delay: MinD, restarted: (rd_per != '0),
                       last: 1'b0};
            idx_r <= '0;
            state_r <= (count_r == KW'(ResultLimit)) ? S_MIN : S_PICK;
          end
        end
        S_MIN: begin
          if (rd_live && (!any_r || rd_dl < first_r)) begin
            any_r <= 1'b1;
            first_r <= rd_dl;
          end
          idx_r <= idx_r + 1'b1;
          if (!more) state_r <= S_OUT;
        end
        S_OUT: begin
          // the held expired result, or a new one, gets the final fields
          if (c_r.op == OP_ADD) begin
            if (!rv_r) begin
              res_r <= '{status: ST_ADDED, slot: 4'(free_r),
                         earliest_changed: earliest_r, rearm: earliest_r,
                         next_delay: earliest_r ? delay : MinD, restarted: 1'b0,
                         last: 1'b1};
              state_r <= S_IDLE;
            end
          end else if (count_r == '0) begin
            if (!rv_r) begin
              res_r <= '{status: ST_NONE_DUE, slot: 4'd0, earliest_changed: 1'b0,
                         rearm: any_r, next_delay: any_r ? delay : MinD,
                         restarted: 1'b0, last: 1'b1};
              state_r <= S_IDLE;
            end
          end else begin
            res_r.rearm <= any_r;
            res_r.next_delay <= any_r ? delay : MinD;
            res_r.last <= 1'b1;
            state_r <= S_IDLE;
          end
        end
        default: state_r <= S_IDLE;
      endcase
    end
  end

endmodule

### design/deadline_timer_queue.sv
// ----------------------------------------------------------------------------
// deadline_timer_queue
// ordered timer queue with one-shot and periodic timers
// ----------------------------------------------------------------------------
// add: a scan of the slot store one slot per cycle, then the write of a free slot
// cancel: answered from the idle state; tick: a pick scan per expired timer, then a scan for the earliest deadline
// a tick also waits while an earlier expired transaction is not yet popped
// every scan reads one slot of the deadline store per cycle
// one item at a time in the back end; a two-entry command queue in front
// synchronous active-low reset empties queues and frees every slot
module deadline_timer_queue #(
  parameter int TIMERS       = dtq_pkg::TimersDefault,
  parameter int MIN_DELAY_US = dtq_pkg::MinDelayDefault
) (
  input  logic                      clk,
  input  logic                      rst_n,
  input  logic                      push,
  output logic                      full,
  input  logic [1:0]                in_operation,
  input  logic [dtq_pkg::TimeW-1:0] in_deadline,
  input  logic [dtq_pkg::PeriodW-1:0] in_period,
  input  logic [3:0]                in_target_slot,
  input  logic [dtq_pkg::TimeW-1:0] in_current_time,
  output logic                      empty,
  input  logic                      pop,
  output logic [2:0]                out_status,
  output logic [3:0]                out_slot,
  output logic                      out_earliest_changed,
  output logic                      out_rearm,
  output logic [dtq_pkg::TimeW-1:0] out_next_delay,
  output logic                      out_restarted,
  output logic                      out_last
);
  import dtq_pkg::*;

  `include "deadline_timer_queue_assert.svh"

  cmd_t cin, cq;
  res_t r;
  logic cv, ct, rv, busy;

  assign cin = '{op: op_t'(in_operation), deadline: in_deadline, period: in_period,
                 target: in_target_slot, now: in_current_time};

  dtq_front u_front (
    .clk(clk), .rst_n(rst_n), .push(push), .full(full), .cmd_in(cin),
    .cmd_valid(cv), .cmd_out(cq), .cmd_take(ct)
  );

  dtq_back #(.TIMERS(TIMERS), .MIN_DELAY_US(MIN_DELAY_US)) u_back (
    .clk(clk), .rst_n(rst_n), .cmd_valid(cv), .cmd(cq), .cmd_take(ct),
    .res_valid(rv), .res(r), .res_take(pop), .busy(busy)
  );

  assign empty                = !rv;
  assign out_status           = r.status;
  assign out_slot             = r.slot;
  assign out_earliest_changed = r.earliest_changed;
  assign out_rearm            = r.rearm;
  assign out_next_delay       = r.next_delay;
  assign out_restarted        = r.restarted;
  assign out_last             = r.last;

  `DTQ_ASSERT_IMP(a_rearm_last, !empty && out_rearm, out_last)
  `DTQ_ASSERT_IMP(a_delay_min, !empty && !out_rearm,
                  out_next_delay == TimeW'(MIN_DELAY_US))
  `DTQ_ASSERT_NEXT(a_take_idle, ct && cv, busy || !empty)

endmodule
